>>> design/scored_bucket_priority_stack_assert.svh
// Assertion macros used by the checker of the scored bucket priority stack.
// Depends on nothing; the including module provides clock and reset.
`ifndef SCORED_BUCKET_PRIORITY_STACK_ASSERT_SVH
`define SCORED_BUCKET_PRIORITY_STACK_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define SBPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SBPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/sbps_pkg.sv
// Package of the scored bucket priority stack: command, status and register codes,
// the packed entry record and the controller/datapath interface structs. No dependencies.
`default_nettype none
package sbps_pkg;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   localparam logic [1:0] CSR_MISMATCH   = 2'd0;
   localparam logic [1:0] CSR_GAP_OPEN   = 2'd1;
   localparam logic [1:0] CSR_GAP_EXTEND = 2'd2;

   localparam int POS_W     = 10;
   localparam int COUNT_W   = 5;
   localparam int STATE_W   = 2;
   localparam int PEN_W     = 6;
   localparam int PROD_W    = COUNT_W + PEN_W;
   localparam int SCORE_W   = PROD_W + 2;
   localparam int ENTRIES_W = 12;
   localparam int WORD_W    = 32;

   localparam logic [PEN_W-1:0] MISMATCH_RESET   = 6'd3;
   localparam logic [PEN_W-1:0] GAP_OPEN_RESET   = 6'd11;
   localparam logic [PEN_W-1:0] GAP_EXTEND_RESET = 6'd4;

   typedef struct packed {
      logic [POS_W-1:0]   last_diff;
      logic [STATE_W-1:0] align_state;
      logic [COUNT_W-1:0] deletions;
      logic [COUNT_W-1:0] insertions;
      logic [COUNT_W-1:0] gap_extends;
      logic [COUNT_W-1:0] gap_opens;
      logic [COUNT_W-1:0] mismatches;
      logic [POS_W-1:0]   position;
   } entry_info_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic read;
      logic exec;
      logic scan;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic rsp_free;
   } dp_stat_type;

   // Index of the lowest set bit of a word; zero when the word is empty.
   function automatic logic [4:0] lowest_set(input logic [WORD_W-1:0] w);
      logic [4:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) idx = 5'(i);
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

>>> design/sbps_ctrl.sv
// Sequencing state machine of the scored bucket priority stack.
// Depends on sbps_pkg; drives the datapath through dp_cmd_type.
`default_nettype none
module sbps_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  sbps_pkg::dp_stat_type stat,
   output sbps_pkg::dp_cmd_type  cmd
);
   import sbps_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_scan ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> design/sbps_datapath.sv
// Datapath of the scored bucket priority stack: penalty registers, score, bucket fill
// memory with occupancy bitmap, entry memories and the response register. Uses sbps_pkg.
`default_nettype none
module sbps_datapath #(
   parameter int NUM_LEVELS  = 64,
   parameter int LEVEL_DEPTH = 32,
   parameter int SA_BITS     = 40
) (
   input  wire                                clock,
   input  wire                                reset,
   input  sbps_pkg::dp_cmd_type               cmd,
   output sbps_pkg::dp_stat_type              stat,
   input  wire                                csr_we,
   input  wire  [1:0]                         csr_index,
   input  wire  [sbps_pkg::PEN_W-1:0]         csr_wdata,
   input  wire  [1:0]                         req_command,
   input  wire  [sbps_pkg::POS_W-1:0]         req_position,
   input  wire  [SA_BITS-1:0]                 req_sa_low,
   input  wire  [SA_BITS-1:0]                 req_sa_high,
   input  wire  [sbps_pkg::COUNT_W-1:0]       req_mismatches,
   input  wire  [sbps_pkg::COUNT_W-1:0]       req_gap_opens,
   input  wire  [sbps_pkg::COUNT_W-1:0]       req_gap_extends,
   input  wire  [sbps_pkg::COUNT_W-1:0]       req_insertions,
   input  wire  [sbps_pkg::COUNT_W-1:0]       req_deletions,
   input  wire  [sbps_pkg::STATE_W-1:0]       req_align_state,
   input  wire                                req_is_diff,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [sbps_pkg::ENTRIES_W-1:0]     rsp_entries_total,
   output logic [sbps_pkg::POS_W-1:0]         rsp_out_position,
   output logic [SA_BITS-1:0]                 rsp_out_sa_low,
   output logic [SA_BITS-1:0]                 rsp_out_sa_high,
   output logic [sbps_pkg::COUNT_W-1:0]       rsp_out_mismatches,
   output logic [sbps_pkg::COUNT_W-1:0]       rsp_out_gap_opens,
   output logic [sbps_pkg::COUNT_W-1:0]       rsp_out_gap_extends,
   output logic [sbps_pkg::COUNT_W-1:0]       rsp_out_insertions,
   output logic [sbps_pkg::COUNT_W-1:0]       rsp_out_deletions,
   output logic [sbps_pkg::STATE_W-1:0]       rsp_out_align_state,
   output logic [sbps_pkg::POS_W-1:0]         rsp_out_last_diff
);
   import sbps_pkg::*;

   localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(NUM_LEVELS);
   localparam int LVL_W  = $clog2(NUM_LEVELS + 1);
   localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int NWORDS = (NUM_LEVELS + WORD_W - 1) / WORD_W;
   localparam int WRD_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   // Captured request.
   logic [1:0]           cmd_ff;
   entry_info_type       info_ff;
   logic [SA_BITS-1:0]   sal_ff, sah_ff;

   logic [PEN_W-1:0]     pen_mm_ff, pen_go_ff, pen_ge_ff;
   logic [PROD_W-1:0]    prod_mm_ff, prod_go_ff, prod_ge_ff;
   logic [SCORE_W-1:0]   score_sum;

   // Bucket fill memory; a clear bitmap bit means the bucket holds nothing.
   logic [FILL_W-1:0]    fill_mem [NUM_LEVELS];
   logic [FILL_W-1:0]    fill_rd_ff;
   logic                 fill_vld_ff;
   logic [IDX_W-1:0]     idx_ff, rd_idx;
   logic                 range_ok_ff, range_ok_in;
   logic [NUM_LEVELS-1:0] bitmap_ff;
   logic [NWORDS-1:0][WORD_W-1:0] bm_words;

   logic [CNT_W-1:0]     total_ff;
   logic [LVL_W-1:0]     best_ff;
   logic [WRD_W-1:0]     scan_ff;

   // Entry memories, one slot per bucket position.
   logic [SA_BITS-1:0]   sal_mem [SLOTS];
   logic [SA_BITS-1:0]   sah_mem [SLOTS];
   entry_info_type       info_mem [SLOTS];
   logic [SA_BITS-1:0]   rd_sal_ff, rd_sah_ff;
   entry_info_type       rd_info_ff;

   logic [1:0]           status_ff;
   logic                 pop_ok_ff;
   logic                 rsp_valid_ff;

   logic [FILL_W-1:0]    fill_cur, fill_new;
   logic                 is_push, is_pop, push_ok, pop_ok;
   logic [SLOT_W-1:0]    slot_addr;
   logic [WORD_W-1:0]    scan_word;
   logic                 scan_found, scan_last;

   assign score_sum = SCORE_W'(prod_mm_ff) + SCORE_W'(prod_go_ff) + SCORE_W'(prod_ge_ff);
   assign is_push   = (cmd_ff == CMD_PUSH);
   assign is_pop    = (cmd_ff == CMD_POP);
   assign rd_idx    = is_push ? IDX_W'(score_sum) : IDX_W'(best_ff);
   assign range_ok_in = is_push ? (32'(score_sum) < 32'(NUM_LEVELS))
                                : (32'(best_ff) < 32'(NUM_LEVELS));

   assign fill_cur = fill_vld_ff ? fill_rd_ff : '0;
   assign push_ok  = is_push && range_ok_ff && (fill_cur != FILL_W'(LEVEL_DEPTH));
   assign pop_ok   = is_pop && (total_ff != '0) && range_ok_ff && (fill_cur != '0);
   assign fill_new = is_push ? fill_cur + 1'b1 : fill_cur - 1'b1;
   assign slot_addr = SLOT_W'(idx_ff) * SLOT_W'(LEVEL_DEPTH)
                    + (is_push ? SLOT_W'(fill_cur) : SLOT_W'(fill_new));

   always_comb begin
      bm_words = '0;
      bm_words[NWORDS-1:0] = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         bm_words[i / WORD_W][i % WORD_W] = bitmap_ff[i];
      end
   end

   // Every bucket below the one just emptied is empty, so the scan needs no mask.
   assign scan_word  = bm_words[scan_ff];
   assign scan_found = |scan_word;
   assign scan_last  = (32'(scan_ff) == 32'(NWORDS - 1));

   assign stat.need_scan = pop_ok && (total_ff != CNT_W'(1)) && (fill_new == '0);
   assign stat.scan_done = scan_found || scan_last;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_mm_ff <= MISMATCH_RESET;
         pen_go_ff <= GAP_OPEN_RESET;
         pen_ge_ff <= GAP_EXTEND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MISMATCH:   pen_mm_ff <= csr_wdata;
            CSR_GAP_OPEN:   pen_go_ff <= csr_wdata;
            CSR_GAP_EXTEND: pen_ge_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Request capture and score products.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff                <= req_command;
         sal_ff                <= req_sa_low;
         sah_ff                <= req_sa_high;
         info_ff.position      <= req_position;
         info_ff.mismatches    <= req_mismatches;
         info_ff.gap_opens     <= req_gap_opens;
         info_ff.gap_extends   <= req_gap_extends;
         info_ff.insertions    <= req_insertions;
         info_ff.deletions     <= req_deletions;
         info_ff.align_state   <= req_align_state;
         info_ff.last_diff     <= req_is_diff ? req_position : '0;
      end
      if (cmd.calc) begin
         prod_mm_ff <= PROD_W'(info_ff.mismatches) * PROD_W'(pen_mm_ff);
         prod_go_ff <= PROD_W'(info_ff.gap_opens) * PROD_W'(pen_go_ff);
         prod_ge_ff <= PROD_W'(info_ff.gap_extends) * PROD_W'(pen_ge_ff);
      end
      if (cmd.read) begin
         fill_rd_ff  <= fill_mem[rd_idx];
         fill_vld_ff <= bitmap_ff[rd_idx];
         idx_ff      <= rd_idx;
         range_ok_ff <= range_ok_in;
      end
   end

   // On success, push writes fill and entry memories; pop writes fill, reads entries.
   always_ff @(posedge clock) begin
      if (cmd.exec && (push_ok || pop_ok)) fill_mem[idx_ff] <= fill_new;
      if (cmd.exec && push_ok) begin
         sal_mem[slot_addr]  <= sal_ff;
         sah_mem[slot_addr]  <= sah_ff;
         info_mem[slot_addr] <= info_ff;
      end
      if (cmd.exec && pop_ok) begin
         rd_sal_ff  <= sal_mem[slot_addr];
         rd_sah_ff  <= sah_mem[slot_addr];
         rd_info_ff <= info_mem[slot_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff <= '0;
         total_ff  <= '0;
         best_ff   <= LVL_W'(NUM_LEVELS);
         status_ff <= STATUS_OK;
         pop_ok_ff <= 1'b0;
         scan_ff   <= '0;
      end else if (cmd.exec) begin
         status_ff <= STATUS_OK;
         pop_ok_ff <= pop_ok;
         scan_ff   <= WRD_W'(idx_ff >> 5);
         case (cmd_ff)
            CMD_PUSH: begin
               if (push_ok) begin
                  bitmap_ff[idx_ff] <= 1'b1;
                  total_ff <= total_ff + 1'b1;
                  if (32'(best_ff) > 32'(idx_ff)) best_ff <= LVL_W'(idx_ff);
               end else begin
                  status_ff <= STATUS_DROPPED;
               end
            end
            CMD_POP: begin
               if (pop_ok) begin
                  bitmap_ff[idx_ff] <= (fill_new != '0);
                  total_ff <= total_ff - 1'b1;
                  if (total_ff == CNT_W'(1)) best_ff <= LVL_W'(NUM_LEVELS);
               end else begin
                  status_ff <= STATUS_EMPTY;
               end
            end
            CMD_CLEAR: begin
               bitmap_ff <= '0;
               total_ff  <= '0;
               best_ff   <= LVL_W'(NUM_LEVELS);
            end
            default: ;
         endcase
      end else if (cmd.scan) begin
         if (scan_found) begin
            best_ff <= LVL_W'(32'(scan_ff) * WORD_W + 32'(lowest_set(scan_word)));
         end else if (scan_last) begin
            best_ff <= LVL_W'(NUM_LEVELS);
         end else begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status          <= status_ff;
         rsp_entries_total   <= ENTRIES_W'(total_ff);
         rsp_out_position    <= pop_ok_ff ? rd_info_ff.position : '0;
         rsp_out_sa_low      <= pop_ok_ff ? rd_sal_ff : '0;
         rsp_out_sa_high     <= pop_ok_ff ? rd_sah_ff : '0;
         rsp_out_mismatches  <= pop_ok_ff ? rd_info_ff.mismatches : '0;
         rsp_out_gap_opens   <= pop_ok_ff ? rd_info_ff.gap_opens : '0;
         rsp_out_gap_extends <= pop_ok_ff ? rd_info_ff.gap_extends : '0;
         rsp_out_insertions  <= pop_ok_ff ? rd_info_ff.insertions : '0;
         rsp_out_deletions   <= pop_ok_ff ? rd_info_ff.deletions : '0;
         rsp_out_align_state <= pop_ok_ff ? rd_info_ff.align_state : '0;
         rsp_out_last_diff   <= pop_ok_ff ? rd_info_ff.last_diff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> design/scored_bucket_priority_stack.sv
// Top level of the scored bucket priority stack: controller plus datapath.
// Depends on sbps_pkg, sbps_ctrl and sbps_datapath.
//
//   Channel   Handshake              Payload
//   req       req_valid/req_ready    command, entry fields
//   rsp       rsp_valid/rsp_ready    status, entries_total, popped entry
//   csr       csr_we                 csr_index, csr_wdata (6 bits)
//
// An accepted request is captured, then passes through the score products, the fill memory
// read and the execute step (fill memory write, entry memory access); when a pop empties
// the best bucket but leaves entries, the bitmap is then scanned in 32-bucket words, up to
// ceil(NUM_LEVELS/32) of them, before the response is loaded. A new request is accepted
// only from the idle state. Reset is synchronous; it clears the counters and bucket bitmap
// at once, no clearing pass. A new request is accepted while the previous response waits;
// a stalled response holds the controller in its final state.
`default_nettype none
module scored_bucket_priority_stack #(
   parameter int NUM_LEVELS  = 64,
   parameter int LEVEL_DEPTH = 32,
   parameter int SA_BITS     = 40
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [1:0]                     req_command,
   input  wire  [sbps_pkg::POS_W-1:0]     req_position,
   input  wire  [SA_BITS-1:0]             req_sa_low,
   input  wire  [SA_BITS-1:0]             req_sa_high,
   input  wire  [sbps_pkg::COUNT_W-1:0]   req_mismatches,
   input  wire  [sbps_pkg::COUNT_W-1:0]   req_gap_opens,
   input  wire  [sbps_pkg::COUNT_W-1:0]   req_gap_extends,
   input  wire  [sbps_pkg::COUNT_W-1:0]   req_insertions,
   input  wire  [sbps_pkg::COUNT_W-1:0]   req_deletions,
   input  wire  [sbps_pkg::STATE_W-1:0]   req_align_state,
   input  wire                            req_is_diff,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [sbps_pkg::ENTRIES_W-1:0] rsp_entries_total,
   output logic [sbps_pkg::POS_W-1:0]     rsp_out_position,
   output logic [SA_BITS-1:0]             rsp_out_sa_low,
   output logic [SA_BITS-1:0]             rsp_out_sa_high,
   output logic [sbps_pkg::COUNT_W-1:0]   rsp_out_mismatches,
   output logic [sbps_pkg::COUNT_W-1:0]   rsp_out_gap_opens,
   output logic [sbps_pkg::COUNT_W-1:0]   rsp_out_gap_extends,
   output logic [sbps_pkg::COUNT_W-1:0]   rsp_out_insertions,
   output logic [sbps_pkg::COUNT_W-1:0]   rsp_out_deletions,
   output logic [sbps_pkg::STATE_W-1:0]   rsp_out_align_state,
   output logic [sbps_pkg::POS_W-1:0]     rsp_out_last_diff,
   input  wire                            csr_we,
   input  wire  [1:0]                     csr_index,
   input  wire  [sbps_pkg::PEN_W-1:0]     csr_wdata
);
   import sbps_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   sbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   sbps_datapath #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .SA_BITS     (SA_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .stat                (dp_stat),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_command         (req_command),
      .req_position        (req_position),
      .req_sa_low          (req_sa_low),
      .req_sa_high         (req_sa_high),
      .req_mismatches      (req_mismatches),
      .req_gap_opens       (req_gap_opens),
      .req_gap_extends     (req_gap_extends),
      .req_insertions      (req_insertions),
      .req_deletions       (req_deletions),
      .req_align_state     (req_align_state),
      .req_is_diff         (req_is_diff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_entries_total   (rsp_entries_total),
      .rsp_out_position    (rsp_out_position),
      .rsp_out_sa_low      (rsp_out_sa_low),
      .rsp_out_sa_high     (rsp_out_sa_high),
      .rsp_out_mismatches  (rsp_out_mismatches),
      .rsp_out_gap_opens   (rsp_out_gap_opens),
      .rsp_out_gap_extends (rsp_out_gap_extends),
      .rsp_out_insertions  (rsp_out_insertions),
      .rsp_out_deletions   (rsp_out_deletions),
      .rsp_out_align_state (rsp_out_align_state),
      .rsp_out_last_diff   (rsp_out_last_diff)
   );

endmodule
`default_nettype wire

>>> design/sbps_checker.sv
// Port-level checker for the scored bucket priority stack, bound to the top level.
// Depends on sbps_pkg and scored_bucket_priority_stack_assert.svh.
`default_nettype none
`include "scored_bucket_priority_stack_assert.svh"
module sbps_checker #(
   parameter int NUM_LEVELS  = 64,
   parameter int LEVEL_DEPTH = 32
) (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [1:0]                      rsp_status,
   input wire [sbps_pkg::ENTRIES_W-1:0]  rsp_entries_total,
   input wire [sbps_pkg::POS_W-1:0]      rsp_out_position
);
   import sbps_pkg::*;

   localparam int SLOT_CAPACITY = NUM_LEVELS * LEVEL_DEPTH;

   `SBPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_entries_total), "response changed while stalled")
   `SBPS_ASSERT(a_one_request, req_valid && req_ready |=> !req_ready, "second request accepted while one is in work")
   `SBPS_ASSERT(a_fail_zero, rsp_valid && rsp_status != STATUS_OK |-> rsp_out_position == '0, "failed request returned entry data")
   `SBPS_ASSERT_ALWAYS(a_total_bound, rsp_valid |-> 32'(rsp_entries_total) <= SLOT_CAPACITY, "entry count above capacity")

endmodule

bind scored_bucket_priority_stack sbps_checker #(
   .NUM_LEVELS  (NUM_LEVELS),
   .LEVEL_DEPTH (LEVEL_DEPTH)
) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_entries_total (rsp_entries_total),
   .rsp_out_position  (rsp_out_position)
);
`default_nettype wire
